>>> rtl/core/deq_pkg.sv
// Shared types and constants for the double-ended queue.
// Holds the command and error codes and the default sizes.
// No dependencies.
package deq_pkg;

  localparam int DEQ_DEPTH      = 16;
  localparam int DEQ_DATA_WIDTH = 32;
  localparam int CMD_WIDTH      = 3;
  localparam int ERR_WIDTH      = 2;

  typedef enum logic [CMD_WIDTH-1:0] {
    CMD_NONE       = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_PUSH_BACK  = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_BACK   = 3'd4
  } cmd_t;

  typedef enum logic [ERR_WIDTH-1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_t;

endpackage

>>> rtl/core/deq_in_if.sv
// Input channel of the double-ended queue: valid/ready plus command and value.
// Depends on deq_pkg for the command width and default sizes.
interface deq_in_if
  import deq_pkg::*;
#(
  parameter int DATA_WIDTH = DEQ_DATA_WIDTH
);
  logic                  valid;
  logic                  ready;
  logic [CMD_WIDTH-1:0]  command;
  logic [DATA_WIDTH-1:0] push_value;

  modport source (output valid, output command, output push_value, input ready);
  modport sink   (input valid, input command, input push_value, output ready);
endinterface

>>> rtl/core/deq_out_if.sv
// Result channel of the double-ended queue: valid/ready plus one result item.
// Depends on deq_pkg for the error-code width and default sizes.
interface deq_out_if
  import deq_pkg::*;
#(
  parameter int DATA_WIDTH = DEQ_DATA_WIDTH,
  parameter int DEPTH      = DEQ_DEPTH
);
  localparam int CW = $clog2(DEPTH + 1);

  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] removed_value;
  logic [DATA_WIDTH-1:0] front_value;
  logic [DATA_WIDTH-1:0] back_value;
  logic [CW-1:0]         occupancy;
  logic                  is_empty;
  logic                  is_full;
  logic [ERR_WIDTH-1:0]  error_code;

  modport source (
    output valid, output removed_value, output front_value, output back_value,
    output occupancy, output is_empty, output is_full, output error_code,
    input ready
  );
  modport sink (
    input valid, input removed_value, input front_value, input back_value,
    input occupancy, input is_empty, input is_full, input error_code,
    output ready
  );
endinterface

>>> rtl/core/double_ended_queue.sv
// Bounded double-ended queue kept as a ring in one RAM, with head/tail indexes
// and a count. Depends on deq_pkg, deq_in_if, deq_out_if and deq_ram.
//
// Usage:
//   in_chan carries a command (none/peek, push front, push back, pop front,
//   pop back) and a push value. Every accepted item gives exactly one result
//   item on out_chan: the popped element, the front and back elements after
//   the step, the occupancy, empty/full flags and an error code. A pop on an
//   empty queue or a push on a full one is flagged and leaves the state alone.
//   Unused command codes act as a peek.
//   Latency and throughput: unless a refill is needed, the result item is offered
//   in the cycle after its item is accepted, and one item per cycle passes while
//   results are taken. A pop that leaves two or more elements needs a refill: the
//   new end element comes from the registered RAM read in S_READ, and that item holds off the next one.
//   The front and back elements are cached in registers; the RAM is read only for that refill.
//   Reset (synchronous, active low) empties the queue; RAM contents are not
//   cleared and no slot is read before it is written.
//   When the receiver stalls the result is held, and no new item is accepted
//   until the waiting result is taken (it may be taken and replaced in one
//   cycle).
module double_ended_queue
  import deq_pkg::*;
#(
  parameter int DEPTH      = DEQ_DEPTH,
  parameter int DATA_WIDTH = DEQ_DATA_WIDTH
) (
  input  logic       clk,
  input  logic       rst_n,
  deq_in_if.sink     in_chan,
  deq_out_if.source  out_chan
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t                state_r, state_nxt;
  logic [AW-1:0]         head_r, head_nxt;
  logic [AW-1:0]         tail_r, tail_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [DATA_WIDTH-1:0] front_r, front_nxt;
  logic [DATA_WIDTH-1:0] back_r, back_nxt;
  logic                  refill_front_r, refill_front_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0] out_removed_r, out_removed_nxt;
  logic [DATA_WIDTH-1:0] out_front_r, out_front_nxt;
  logic [DATA_WIDTH-1:0] out_back_r, out_back_nxt;
  logic [CW-1:0]         out_count_r, out_count_nxt;
  logic [ERR_WIDTH-1:0]  out_err_r, out_err_nxt;

  logic                  in_ready;
  logic                  accept;
  logic                  ram_we;
  logic [AW-1:0]         ram_addr;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic                  need_read;
  logic                  is_full;
  logic                  is_empty;
  logic [AW-1:0]         head_inc, head_dec, tail_inc, tail_dec;
  logic [DATA_WIDTH-1:0] removed;
  err_t                  err;

  // ring index steps with wrap at any depth
  assign head_inc = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? LAST_IDX : head_r - 1'b1;
  assign tail_inc = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
  assign tail_dec = (tail_r == '0) ? LAST_IDX : tail_r - 1'b1;

  assign is_full  = (count_r == FULL_CNT);
  assign is_empty = (count_r == '0);

  // take an item only when idle and the result register is free
  assign in_ready      = (state_r == S_IDLE) && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = in_ready;
  assign accept        = in_chan.valid && in_ready;

  // decode the command, update indexes, cache and RAM access
  always_comb begin
    head_nxt         = head_r;
    tail_nxt         = tail_r;
    count_nxt        = count_r;
    front_nxt        = front_r;
    back_nxt         = back_r;
    refill_front_nxt = refill_front_r;
    ram_we           = 1'b0;
    ram_addr         = tail_r;
    need_read        = 1'b0;
    removed          = '0;
    err              = ERR_OK;

    case (in_chan.command)
      CMD_PUSH_FRONT: begin
        if (is_full) begin
          err = ERR_FULL;
        end else begin
          head_nxt  = head_dec;
          count_nxt = count_r + 1'b1;
          ram_we    = 1'b1;
          ram_addr  = head_dec;
          front_nxt = in_chan.push_value;
          if (is_empty) begin
            back_nxt = in_chan.push_value;
          end
        end
      end
      CMD_PUSH_BACK: begin
        if (is_full) begin
          err = ERR_FULL;
        end else begin
          tail_nxt  = tail_inc;
          count_nxt = count_r + 1'b1;
          ram_we    = 1'b1;
          ram_addr  = tail_inc;
          back_nxt  = in_chan.push_value;
          if (is_empty) begin
            front_nxt = in_chan.push_value;
          end
        end
      end
      CMD_POP_FRONT: begin
        if (is_empty) begin
          err = ERR_EMPTY;
        end else begin
          removed          = front_r;
          head_nxt         = head_inc;
          count_nxt        = count_r - 1'b1;
          ram_addr         = head_inc;
          refill_front_nxt = 1'b1;
          if (count_r == CW'(1)) begin
            front_nxt = '0;
            back_nxt  = '0;
          end else if (count_r == CW'(2)) begin
            front_nxt = back_r;
          end else begin
            need_read = 1'b1;
          end
        end
      end
      CMD_POP_BACK: begin
        if (is_empty) begin
          err = ERR_EMPTY;
        end else begin
          removed          = back_r;
          tail_nxt         = tail_dec;
          count_nxt        = count_r - 1'b1;
          ram_addr         = tail_dec;
          refill_front_nxt = 1'b0;
          if (count_r == CW'(1)) begin
            front_nxt = '0;
            back_nxt  = '0;
          end else if (count_r == CW'(2)) begin
            back_nxt = front_r;
          end else begin
            need_read = 1'b1;
          end
        end
      end
      default: begin
        // peek and unused codes: no change
      end
    endcase
  end

  // form the result item and the sequencer step
  always_comb begin
    state_nxt       = state_r;
    out_valid_nxt   = out_valid_r && !out_chan.ready;
    out_removed_nxt = out_removed_r;
    out_front_nxt   = out_front_r;
    out_back_nxt    = out_back_r;
    out_count_nxt   = out_count_r;
    out_err_nxt     = out_err_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_removed_nxt = removed;
          out_front_nxt   = front_nxt;
          out_back_nxt    = back_nxt;
          out_count_nxt   = count_nxt;
          out_err_nxt     = err;
          if (need_read) begin
            state_nxt = S_READ;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_READ: begin
        // patch in the new end element from the RAM
        if (refill_front_r) begin
          out_front_nxt = ram_rdata;
        end else begin
          out_back_nxt = ram_rdata;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= LAST_IDX;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        head_r  <= head_nxt;
        tail_r  <= tail_nxt;
        count_r <= count_nxt;
      end
    end
  end

  // cached ends and result payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      back_r  <= '0;
    end else if (accept) begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
    end else if (state_r == S_READ) begin
      if (refill_front_r) begin
        front_r <= ram_rdata;
      end else begin
        back_r <= ram_rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      refill_front_r <= refill_front_nxt;
    end
    out_removed_r <= out_removed_nxt;
    out_front_r   <= out_front_nxt;
    out_back_r    <= out_back_nxt;
    out_count_r   <= out_count_nxt;
    out_err_r     <= out_err_nxt;
  end

  deq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (accept && ram_we),
    .wr_addr (ram_addr),
    .wr_data (in_chan.push_value),
    .rd_addr (ram_addr),
    .rd_data (ram_rdata)
  );

  // drive the result channel
  assign out_chan.valid         = out_valid_r;
  assign out_chan.removed_value = out_removed_r;
  assign out_chan.front_value   = out_front_r;
  assign out_chan.back_value    = out_back_r;
  assign out_chan.occupancy     = out_count_r;
  assign out_chan.is_empty      = (out_count_r == '0);
  assign out_chan.is_full       = (out_count_r == FULL_CNT);
  assign out_chan.error_code    = out_err_r;

endmodule

>>> rtl/core/deq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, then register the read word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
